FILE: rtl/core/hvr_pkg.sv
// Shared types and constants for the high-voltage channel ramp controller.
// No dependencies; every other file in rtl/core but hvr_chk refers to this package by scoped names.
package hvr_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int CH_W       = 3;
	localparam int MV_W       = 17;
	localparam int RATE_W     = 10;
	localparam int CUR_W      = 20;
	localparam int TICK_W     = 32;
	localparam int ICPT_W     = 21;
	localparam int SLOPE_W    = 24;
	localparam int CODE_W     = 16;
	localparam int DELTA_W    = 8;
	localparam int STEP_W     = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic MODE_DEMAND  = 1'b0;
	localparam logic MODE_SERVICE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_VOLTAGE   = 3'd0,
		REG_RAMP_UP_RATE  = 3'd1,
		REG_RAMP_DN_RATE  = 3'd2,
		REG_CURRENT_LIMIT = 3'd3,
		REG_DAC_INTERCEPT = 3'd4,
		REG_DAC_SLOPE     = 3'd5,
		REG_DAC_MAX_CODE  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic trip;
		logic down;
		logic up;
		logic demand;
	} flags_t;

	typedef struct packed {
		logic [MV_W-1:0]   actual;
		logic [MV_W-1:0]   target;
		logic [TICK_W-1:0] last;
		flags_t            flags;
	} entry_t;

	typedef struct packed {
		logic [MV_W-1:0]          max_voltage_mv;
		logic [RATE_W-1:0]        ramp_up_rate;
		logic [RATE_W-1:0]        ramp_down_rate;
		logic [CUR_W-1:0]         current_limit_na;
		logic signed [ICPT_W-1:0] dac_intercept;
		logic [SLOPE_W-1:0]       dac_slope;
		logic [CODE_W-1:0]        dac_max_code;
	} cfg_t;

	localparam flags_t FLAGS_RESET = '{trip: 1'b0, down: 1'b0, up: 1'b0, demand: 1'b1};
	localparam flags_t FLAGS_TRIP  = '{trip: 1'b1, down: 1'b0, up: 1'b0, demand: 1'b0};

	localparam entry_t ENTRY_RESET = '{
		actual: '0,
		target: '0,
		last:   '0,
		flags:  FLAGS_RESET
	};

	localparam cfg_t CFG_RESET = '{
		max_voltage_mv:   17'd90000,
		ramp_up_rate:     10'd5,
		ramp_down_rate:   10'd5,
		current_limit_na: 20'hFFFFF,
		dac_intercept:    21'sd0,
		dac_slope:        24'd0,
		dac_max_code:     16'hFFFF
	};

endpackage

FILE: rtl/core/hvr_in_if.sv
// Input item channel: valid/ready handshake plus the demand/service payload.
// Depends on hvr_pkg for field widths.
interface hvr_in_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [hvr_pkg::CH_W-1:0]      channel;
	logic [hvr_pkg::MV_W-1:0]      demand_mv;
	logic [hvr_pkg::CUR_W-1:0]     measured_current_na;
	logic [hvr_pkg::TICK_W-1:0]    now_ticks;
	logic                          pump_on;

	modport source (
		output valid, mode, channel, demand_mv, measured_current_na, now_ticks, pump_on,
		input  ready
	);
	modport sink (
		input  valid, mode, channel, demand_mv, measured_current_na, now_ticks, pump_on,
		output ready
	);
endinterface

FILE: rtl/core/hvr_out_if.sv
// Result channel: valid/ready handshake plus the per-item channel report.
// Depends on hvr_pkg for field widths.
interface hvr_out_if;
	logic                          valid;
	logic                          ready;
	logic [hvr_pkg::CH_W-1:0]      out_channel;
	logic [hvr_pkg::MV_W-1:0]      actual_mv;
	logic [hvr_pkg::CODE_W-1:0]    dac_code;
	logic                          dac_write;
	logic                          tripped;
	logic                          ramping_up;
	logic                          ramping_down;

	modport source (
		output valid, out_channel, actual_mv, dac_code, dac_write, tripped,
		       ramping_up, ramping_down,
		input  ready
	);
	modport sink (
		input  valid, out_channel, actual_mv, dac_code, dac_write, tripped,
		       ramping_up, ramping_down,
		output ready
	);
endinterface

FILE: rtl/core/hvr_cfg_if.sv
// Configuration write channel: valid/ready handshake, register index and write data.
// Depends on hvr_pkg for widths.
interface hvr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [hvr_pkg::CFG_IDX_W-1:0]     index;
	logic [hvr_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/hvr_dac_conv.sv
// Voltage to DAC code conversion: ceiling, slope multiply (registered), intercept, clamp.
// Depends on hvr_pkg (cfg_t, widths).
module hvr_dac_conv (
	input  logic                          clk,
	input  hvr_pkg::cfg_t                 cfg,
	input  logic                          load,
	input  logic [hvr_pkg::MV_W-1:0]      mv,
	output logic [hvr_pkg::CODE_W-1:0]    code
);
	localparam int PROD_W = hvr_pkg::SLOPE_W + hvr_pkg::MV_W;
	localparam int Q_W    = PROD_W + 2;
	localparam int C_W    = Q_W - 16;

	logic [hvr_pkg::MV_W-1:0] v_clip;
	logic [PROD_W-1:0]        prod_s1;
	logic signed [Q_W-1:0]    icpt_x;
	logic signed [Q_W-1:0]    q;
	logic [C_W-1:0]           c;

	assign v_clip = (mv >= cfg.max_voltage_mv) ? cfg.max_voltage_mv : mv;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PROD_W'(cfg.dac_slope) * PROD_W'(v_clip);
		end
	end

	// q = intercept * 2^16 - slope * v, floor by 2^16, clamp to [0, max]
	assign icpt_x = Q_W'($signed({cfg.dac_intercept, 16'h0000}));
	assign q      = icpt_x - $signed({2'b00, prod_s1});
	assign c      = q[Q_W-1:16];

	always_comb begin
		if (q[Q_W-1]) begin
			code = '0;
		end else if (c > C_W'(cfg.dac_max_code)) begin
			code = cfg.dac_max_code;
		end else begin
			code = c[hvr_pkg::CODE_W-1:0];
		end
	end
endmodule

FILE: rtl/core/hv_channel_ramp_with_trip_core.sv
// Top level of the per-channel high-voltage ramp controller with current trip.
// Depends on hvr_pkg, hvr_in_if, hvr_out_if, hvr_cfg_if and hvr_dac_conv.
//
// Usage:
//   item   - input channel. mode 0 stores a new demand for a channel, mode 1 runs one
//            service step (trip check, ramp start or ramp step). One transfer per item.
//   result - one transfer per item: channel, present voltage, DAC code, DAC write strobe
//            and the trip/ramp flags after the item.
//   cfg    - register writes (index 0..6: ceiling, up rate, down rate, current limit,
//            DAC intercept, DAC slope, DAC max code). Always ready; write only while idle.
// Sequence: the item passes ST_READ, ST_STEP, ST_MUL and ST_FIN in turn; the result
//   is loaded into the output register from ST_FIN. One item at a time: the channel
//   memory read, the ramp multiply, the add/compare with write back, and the registered
//   DAC slope multiply run in turn; the next item is taken at the edge that loads the result.
// Reset: configuration returns to its defaults and every channel reads as zero volts with
//   the demand-changed flag set (per-channel valid bits, no clearing pass needed).
// Stall: a result waits in the output register; the block still takes the next item and
//   holds it finished in its last stage until the output register frees up.
module hv_channel_ramp_with_trip_core (
	input  logic        clk,
	input  logic        arst_n,
	hvr_in_if.sink      item,
	hvr_out_if.source   result,
	hvr_cfg_if.sink     cfg
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_STEP,
		ST_MUL,
		ST_FIN
	} state_t;

	localparam int SUM_W = hvr_pkg::STEP_W + 1;
	localparam int PRD_W = hvr_pkg::RATE_W + hvr_pkg::DELTA_W;

	state_t state_q;

	// configuration
	hvr_pkg::cfg_t cfg_q;

	// item registers, loaded on the input transfer
	logic                          mode_q;
	logic [hvr_pkg::CH_W-1:0]      chan_q;
	logic [hvr_pkg::MV_W-1:0]      demand_q;
	logic [hvr_pkg::CUR_W-1:0]     cur_q;
	logic [hvr_pkg::TICK_W-1:0]    now_q;
	logic                          pump_q;

	// channel state memory
	hvr_pkg::entry_t               mem [0:hvr_pkg::CHANNELS-1];
	logic [hvr_pkg::CHANNELS-1:0]  vld_q;
	hvr_pkg::entry_t               rd_s1;
	logic                          rd_vld_s1;
	hvr_pkg::entry_t               ent;
	logic [hvr_pkg::CH_IDX_W-1:0]  rd_addr;
	logic [hvr_pkg::CH_IDX_W-1:0]  wr_addr;
	logic                          mem_we;

	// ramp pipeline
	hvr_pkg::flags_t               f_start;
	logic [hvr_pkg::DELTA_W-1:0]   delta;
	logic [hvr_pkg::RATE_W-1:0]    rate_sel;
	logic [PRD_W-1:0]              rate_x_delta;
	hvr_pkg::flags_t               f_start_s2;
	logic [hvr_pkg::STEP_W-1:0]    step_s2;
	logic                          dnz_s2;

	hvr_pkg::entry_t               nxt;
	hvr_pkg::flags_t               f_work;
	logic                          wr_nxt;
	logic [SUM_W-1:0]              up_sum;
	logic signed [SUM_W-1:0]       dn_diff;

	logic [hvr_pkg::MV_W-1:0]      act_s3;
	hvr_pkg::flags_t               flags_s3;
	logic                          wr_s3;

	logic [hvr_pkg::CODE_W-1:0]    conv_code;

	logic in_rng;
	logic trip_hit;
	logic item_xfer;
	logic out_free;

	// ---------------------------------------------------------------- handshake
	assign out_free   = !result.valid || result.ready;
	assign item.ready = (state_q == ST_IDLE) || ((state_q == ST_FIN) && out_free);
	assign item_xfer  = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hvr_pkg::CFG_RESET;
		end else if (cfg.valid) begin
			unique case (hvr_pkg::reg_idx_t'(cfg.index))
				hvr_pkg::REG_MAX_VOLTAGE:   cfg_q.max_voltage_mv   <= cfg.data[hvr_pkg::MV_W-1:0];
				hvr_pkg::REG_RAMP_UP_RATE:  cfg_q.ramp_up_rate     <= cfg.data[hvr_pkg::RATE_W-1:0];
				hvr_pkg::REG_RAMP_DN_RATE:  cfg_q.ramp_down_rate   <= cfg.data[hvr_pkg::RATE_W-1:0];
				hvr_pkg::REG_CURRENT_LIMIT: cfg_q.current_limit_na <= cfg.data[hvr_pkg::CUR_W-1:0];
				hvr_pkg::REG_DAC_INTERCEPT: cfg_q.dac_intercept    <= $signed(cfg.data[hvr_pkg::ICPT_W-1:0]);
				hvr_pkg::REG_DAC_SLOPE:     cfg_q.dac_slope        <= cfg.data[hvr_pkg::SLOPE_W-1:0];
				hvr_pkg::REG_DAC_MAX_CODE:  cfg_q.dac_max_code     <= cfg.data[hvr_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- item capture
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			mode_q   <= item.mode;
			chan_q   <= item.channel;
			demand_q <= item.demand_mv;
			cur_q    <= item.measured_current_na;
			now_q    <= item.now_ticks;
			pump_q   <= item.pump_on;
		end
	end

	// channels above the configured count leave state alone and report zeros
	assign in_rng   = int'(chan_q) < hvr_pkg::CHANNELS;
	assign trip_hit = cur_q > cfg_q.current_limit_na;

	// ---------------------------------------------------------------- channel memory
	// Read issued on the input transfer and registered in rd_s1. The write back happens in
	// ST_STEP, and the next read can only come at ST_FIN or later, so no forwarding.
	assign rd_addr = hvr_pkg::CH_IDX_W'(item.channel);
	assign wr_addr = hvr_pkg::CH_IDX_W'(chan_q);
	assign mem_we  = (state_q == ST_STEP) && in_rng;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= nxt;
		end
		if (item_xfer) begin
			rd_s1     <= mem[rd_addr];
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	// an entry never written since reset reads as the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign ent = rd_vld_s1 ? rd_s1 : hvr_pkg::ENTRY_RESET;

	// ---------------------------------------------------------------- ST_READ: ramp start, step size
	always_comb begin
		f_start = ent.flags;
		if (ent.flags.demand) begin
			if ((ent.target > ent.actual) && (cfg_q.ramp_up_rate != '0)) begin
				f_start.up     = 1'b1;
				f_start.down   = 1'b0;
				f_start.demand = 1'b0;
			end
			if ((ent.target < ent.actual) && (cfg_q.ramp_down_rate != '0)) begin
				f_start.down   = 1'b1;
				f_start.up     = 1'b0;
				f_start.demand = 1'b0;
			end
		end
	end

	// a pending demand reloads the step time first, which makes the tick delta zero
	assign delta        = ent.flags.demand ? '0 : (now_q[hvr_pkg::DELTA_W-1:0] -
	                                               ent.last[hvr_pkg::DELTA_W-1:0]);
	assign rate_sel     = f_start.up ? cfg_q.ramp_up_rate : cfg_q.ramp_down_rate;
	assign rate_x_delta = PRD_W'(rate_sel) * PRD_W'(delta);

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			f_start_s2 <= f_start;
			// times 10 mV per volt-tick
			step_s2    <= hvr_pkg::STEP_W'({rate_x_delta, 3'b000}) +
			              hvr_pkg::STEP_W'({rate_x_delta, 1'b0});
			dnz_s2     <= delta != '0;
		end
	end

	// ---------------------------------------------------------------- ST_STEP: update and write back
	assign up_sum  = SUM_W'(ent.actual) + SUM_W'(step_s2);
	assign dn_diff = $signed(SUM_W'(ent.actual)) - $signed(SUM_W'(step_s2));

	always_comb begin
		nxt    = ent;
		f_work = f_start_s2;
		wr_nxt = 1'b0;
		if (mode_q == hvr_pkg::MODE_DEMAND) begin
			nxt.target       = demand_q;
			nxt.flags.trip   = 1'b0;
			nxt.flags.demand = 1'b1;
		end else if (trip_hit) begin
			nxt.actual = '0;
			nxt.flags  = hvr_pkg::FLAGS_TRIP;
			wr_nxt     = 1'b1;
		end else if (pump_q && !ent.flags.trip) begin
			if (ent.flags.demand) begin
				nxt.last = now_q;
			end
			// up and down are never both set
			if (f_work.up && dnz_s2) begin
				if (up_sum >= SUM_W'(ent.target)) begin
					nxt.actual = ent.target;
					f_work.up  = 1'b0;
				end else begin
					nxt.actual = up_sum[hvr_pkg::MV_W-1:0];
				end
				nxt.last = now_q;
				wr_nxt   = 1'b1;
			end else if (f_work.down && dnz_s2) begin
				if (dn_diff <= $signed(SUM_W'(ent.target))) begin
					nxt.actual  = ent.target;
					f_work.down = 1'b0;
				end else begin
					nxt.actual = dn_diff[hvr_pkg::MV_W-1:0];
				end
				nxt.last = now_q;
				wr_nxt   = 1'b1;
			end
			nxt.flags = f_work;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_STEP) begin
			act_s3   <= in_rng ? nxt.actual : '0;
			flags_s3 <= in_rng ? nxt.flags : '0;
			wr_s3    <= in_rng && wr_nxt;
		end
	end

	// ---------------------------------------------------------------- ST_MUL / ST_FIN: DAC code
	hvr_dac_conv u_dac_conv (
		.clk  (clk),
		.cfg  (cfg_q),
		.load (state_q == ST_MUL),
		.mv   (act_s3),
		.code (conv_code)
	);

	// ---------------------------------------------------------------- sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			result.valid        <= 1'b0;
			result.out_channel  <= '0;
			result.actual_mv    <= '0;
			result.dac_code     <= '0;
			result.dac_write    <= 1'b0;
			result.tripped      <= 1'b0;
			result.ramping_up   <= 1'b0;
			result.ramping_down <= 1'b0;
		end else begin
			// a result loading in the same cycle keeps valid high
			if (result.valid && result.ready && !((state_q == ST_FIN) && out_free)) begin
				result.valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_STEP;
				ST_STEP: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						result.valid        <= 1'b1;
						result.out_channel  <= chan_q;
						result.actual_mv    <= act_s3;
						result.dac_code     <= in_rng ? conv_code : '0;
						result.dac_write    <= wr_s3;
						result.tripped      <= flags_s3.trip;
						result.ramping_up   <= flags_s3.up;
						result.ramping_down <= flags_s3.down;
						state_q             <= item_xfer ? ST_READ : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/hvr_chk.sv
// Port-level checker for the ramp controller, bound to the top level.
// Depends on the top level's port names only.
module hvr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  res_channel,
	input logic [16:0] res_actual_mv,
	input logic [15:0] res_dac_code,
	input logic        res_tripped,
	input logic        res_up,
	input logic        res_down
);
	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_channel) &&
		$stable(res_actual_mv) && $stable(res_dac_code))
		else $error("stalled result changed");

	// one item at a time: busy in the cycle after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous one in flight");

	// a tripped channel sits at zero volts with its ramp stopped
	a_trip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_tripped |-> res_actual_mv == '0 && !res_up && !res_down)
		else $error("tripped channel not at rest");

	a_dir_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_up && res_down))
		else $error("ramp up and down both set");
endmodule

bind hv_channel_ramp_with_trip_core hvr_chk u_hvr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_channel   (result.out_channel),
	.res_actual_mv (result.actual_mv),
	.res_dac_code  (result.dac_code),
	.res_tripped   (result.tripped),
	.res_up        (result.ramping_up),
	.res_down      (result.ramping_down)
);
